// File: rtl/clc_pkg.sv
// ---------------------------------------------------------------------------
// clc_pkg: shared types and constants for the circular list store
// Operation kinds, status codes, cell control and default parameters.
// ---------------------------------------------------------------------------
package clc_pkg;

  // default sizing
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  // fixed field widths of the channels
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ELEM_W   = 32;
  localparam int OCC_W    = 5;

  // input operation kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TAIL   = 2'd0,
    KIND_HEAD   = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAIL,
    CELL_PUSH,
    CELL_CLOSE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
  } cell_ctrl_t;

endpackage

// File: rtl/clc_if.sv
// ---------------------------------------------------------------------------
// clc_in_if / clc_out_if: valid/ready channels of the circular list store
// Command channel (kind, value) and result channel (status, element, ...).
// ---------------------------------------------------------------------------
interface clc_in_if;
  logic                                valid;
  logic                                ready;
  clc_pkg::kind_t                      kind;
  logic signed [clc_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface clc_out_if;
  logic                                valid;
  logic                                ready;
  clc_pkg::status_t                    status;
  logic signed [clc_pkg::ELEM_W-1:0]   element;
  logic                                last_of_run;
  logic [clc_pkg::OCC_W-1:0]           occupancy;

  modport source (output valid, output status, output element, output last_of_run,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input element, input last_of_run,
                  input occupancy, output ready);
endinterface

// File: rtl/clc_cell.sv
// ---------------------------------------------------------------------------
// clc_cell: one slot of the list chain
// Holds one element, compares it against the key and moves data to/from
// its neighbors for push, close-up and rotate.
// ---------------------------------------------------------------------------
module clc_cell #(
  parameter int DATA_WIDTH = clc_pkg::DATA_W_DEF,
  parameter int DEPTH      = clc_pkg::DEPTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                          clk,
  input  clc_pkg::cell_ctrl_t           ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  input  logic [DATA_WIDTH-1:0]         value,
  input  logic [DATA_WIDTH-1:0]         left_data,
  input  logic [DATA_WIDTH-1:0]         right_data,
  input  logic [DATA_WIDTH-1:0]         head_data,
  input  logic                          hit_in,
  output logic                          hit_out,
  output logic [DATA_WIDTH-1:0]         data
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  hit_r, hit_nxt;
  logic                  occupied;
  logic                  at_count;
  logic                  at_tail;

  assign occupied = CNT_W'(IDX) < count;
  assign at_count = CNT_W'(IDX) == count;
  assign at_tail  = (CNT_W'(IDX) + CNT_W'(1)) == count;

  // prefix of hits: this cell or any earlier one matched
  assign hit_out = hit_in | hit_r;
  assign data    = data_r;

  // next element
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      clc_pkg::CELL_TAIL: begin
        if (at_count) data_nxt = value;
      end
      clc_pkg::CELL_PUSH: begin
        data_nxt = (IDX == 0) ? value : left_data;
      end
      clc_pkg::CELL_CLOSE: begin
        if (hit_out) data_nxt = right_data;
      end
      clc_pkg::CELL_ROTATE: begin
        data_nxt = at_tail ? head_data : right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  // key compare, kept until the close-up
  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.cmp_en) hit_nxt = occupied && (data_r == value);
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
  end

endmodule

// File: rtl/circular_list_insert_delete.sv
// ---------------------------------------------------------------------------
// circular_list_insert_delete: bounded ordered list in a chain of cells
// Insert at tail or head, delete first match, dump head to tail.
// ---------------------------------------------------------------------------
// timing: insert result registered in the cycle after acceptance; delete
//   compares, then closes up in S_DEL; dump sends elements from S_DUMP
// throughput: inserts one per cycle, dump one element per cycle, while the
//   single shared output register is free; delete and dump block input
// reset: synchronous active-low; clears count and control, cell data is
//   left as is and never read before it is written
module circular_list_insert_delete #(
  parameter int DEPTH      = clc_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = clc_pkg::DATA_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  clc_in_if.sink    in_chan,
  clc_out_if.source out_chan
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DEL, S_DUMP} state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  clc_pkg::status_t              status_r, status_nxt;
  logic signed [clc_pkg::ELEM_W-1:0] elem_r, elem_nxt;
  logic                          last_r, last_nxt;
  logic [clc_pkg::OCC_W-1:0]     occ_r, occ_nxt;

  clc_pkg::cell_ctrl_t           ctrl;
  logic                          slot_free;
  logic                          accept;
  logic                          found;
  logic                          dump_last;
  logic signed [DATA_WIDTH-1:0]  value_d;
  logic signed [DATA_WIDTH-1:0]  head_d;

  logic [DATA_WIDTH-1:0]         cell_data [DEPTH];
  logic                          hit_chain [DEPTH+1];

  // handshake
  assign slot_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE) && slot_free;
  assign accept         = in_chan.valid && in_chan.ready;

  assign value_d   = DATA_WIDTH'(in_chan.value);
  assign head_d    = cell_data[0];
  assign found     = hit_chain[DEPTH];
  assign dump_last = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  // cell chain
  assign hit_chain[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    clc_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .value      (value_d),
      .left_data  ((i == 0) ? value_d : cell_data[(i == 0) ? 0 : i-1]),
      .right_data (cell_data[(i == DEPTH-1) ? i : i+1]),
      .head_data  (cell_data[0]),
      .hit_in     (hit_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .data       (cell_data[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    status_nxt    = status_r;
    elem_nxt      = elem_r;
    last_nxt      = last_r;
    occ_nxt       = occ_r;
    ctrl.op       = clc_pkg::CELL_HOLD;
    ctrl.cmp_en   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          elem_nxt = '0;
          last_nxt = 1'b1;
          case (in_chan.kind)
            clc_pkg::KIND_TAIL, clc_pkg::KIND_HEAD: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = clc_pkg::ST_FULL;
              end else begin
                ctrl.op    = (in_chan.kind == clc_pkg::KIND_TAIL) ?
                             clc_pkg::CELL_TAIL : clc_pkg::CELL_PUSH;
                count_nxt  = count_r + CNT_W'(1);
                status_nxt = clc_pkg::ST_OK;
              end
            end
            clc_pkg::KIND_DELETE: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = clc_pkg::ST_EMPTY;
              end else begin
                ctrl.cmp_en = 1'b1;
                state_nxt   = S_DEL;
              end
            end
            clc_pkg::KIND_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = clc_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DEL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          elem_nxt      = '0;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
          if (found) begin
            ctrl.op    = clc_pkg::CELL_CLOSE;
            count_nxt  = count_r - CNT_W'(1);
            status_nxt = clc_pkg::ST_OK;
          end else begin
            status_nxt = clc_pkg::ST_NOT_FOUND;
          end
        end
      end
      S_DUMP: begin
        // head goes out, list rotates by one
        if (slot_free) begin
          ctrl.op       = clc_pkg::CELL_ROTATE;
          out_valid_nxt = 1'b1;
          status_nxt    = clc_pkg::ST_OK;
          elem_nxt      = clc_pkg::ELEM_W'(head_d);
          last_nxt      = dump_last;
          idx_nxt       = idx_r + IDX_W'(1);
          if (dump_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    occ_nxt = clc_pkg::OCC_W'(count_nxt);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    elem_r   <= elem_nxt;
    last_r   <= last_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.element     = elem_r;
  assign out_chan.last_of_run = last_r;
  assign out_chan.occupancy   = occ_r;

endmodule
